// ----- rtl/core/pps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, limits, register indexes and sequencer states of the
// PID position servo.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int SENSOR_BITS_DEF = 10;
    localparam int GAIN_W          = 16;
    localparam int DEG_W           = 9;
    localparam int ELAPSED_W       = 16;
    localparam int DRIVE_W         = 8;
    localparam int ERR_W           = 13;
    localparam int INTEG_W         = 40;
    localparam int INTEG_LO_W      = 20;
    localparam int MUL_BW          = 21;
    localparam int FRAC_W          = 8;
    localparam int DEN_W           = ELAPSED_W + FRAC_W;
    localparam int TGT_DIVISOR     = 90;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam int ERR_MAX = (1 << (ERR_W - 1)) - 1;
    localparam int ERR_MIN = -(1 << (ERR_W - 1));

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W - 1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W - 1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN    = 3'd0,
        CFG_KD_GAIN    = 3'd1,
        CFG_KI_GAIN    = 3'd2,
        CFG_REF_ZERO   = 3'd3,
        CFG_REF_NINETY = 3'd4,
        CFG_MAX_DRIVE  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAN,
        ST_TDIV,
        ST_TWAIT,
        ST_ERR,
        ST_EI,
        ST_INT,
        ST_PT,
        ST_ILO,
        ST_IHI,
        ST_ICOMB,
        ST_IBIAS,
        ST_IACC,
        ST_DWAIT,
        ST_DACC,
        ST_DRIVE
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/pps_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pps_in_if
// Input item channel: target angle, position sample and elapsed time.
// ----------------------------------------------------------------------------
interface pps_in_if import pps_pkg::*; #(
    parameter int SENSOR_BITS = SENSOR_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [DEG_W-1:0]       target_deg;
    logic        [SENSOR_BITS-1:0] sensor_sample;
    logic        [ELAPSED_W-1:0]   elapsed_ms;

    modport source (
        output valid, target_deg, sensor_sample, elapsed_ms,
        input  ready
    );

    modport sink (
        input  valid, target_deg, sensor_sample, elapsed_ms,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/core/pps_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pps_out_if
// Result item channel: H-bridge duties and the saturated position error.
// ----------------------------------------------------------------------------
interface pps_out_if import pps_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [DRIVE_W-1:0]      drive_a;
    logic [DRIVE_W-1:0]      drive_b;
    logic signed [ERR_W-1:0] position_error;

    modport source (
        output valid, drive_a, drive_b, position_error,
        input  ready
    );

    modport sink (
        input  valid, drive_a, drive_b, position_error,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/core/pps_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pps_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pps_div import pps_pkg::*; #(
    parameter int NUM_W    = GAIN_W + ERR_W - 1,
    parameter int DEN_BITS = DEN_W
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_W-1:0]    i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic                     o_busy,
    output logic [NUM_W-1:0]         o_quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [NUM_W-1:0]    r_num;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   trial_sub;
    logic                fits;

    assign trial     = {r_rem, r_num[NUM_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign fits      = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= CNT_W'(NUM_W - 1);
        end else if (r_busy) begin
            r_rem <= fits ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            r_num <= {r_num[NUM_W-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;
endmodule
`default_nettype wire

// ----- rtl/core/pid_position_servo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_position_servo
// PID position controller: target angle to sensor counts, error, derivative,
// saturating integral, Q8.8 gains, clamped drive split into two PWM duties.
// ----------------------------------------------------------------------------
// Each item steps through the sequencer states, with one pass through the
// one-bit-per-cycle divider for the target and one for the derivative when
// elapsed time is nonzero. A new item is taken only in ST_IDLE, after the last
// one; it may be taken while the previous result waits in the output register.
// Reset: synchronous, active low; clears gains, references, limit, the stored
// error and the integral.
module pid_position_servo import pps_pkg::*; #(
    parameter int SENSOR_BITS = SENSOR_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    pps_in_if.sink                      i_in,
    pps_out_if.source                   o_out
);
    localparam int MUL_AW = (SENSOR_BITS + 1 > ELAPSED_W + 1) ? SENSOR_BITS + 1
                                                               : ELAPSED_W + 1;
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int DIV_NW = (SENSOR_BITS + 8 > GAIN_W + ERR_W - 1) ? SENSOR_BITS + 8
                                                                    : GAIN_W + ERR_W - 1;
    localparam int TW     = (SENSOR_BITS + 4 > ERR_W + 1) ? SENSOR_BITS + 4 : ERR_W + 1;
    localparam int WIDE_W = PROD_W + INTEG_LO_W;
    localparam int ACC_W  = WIDE_W - FRAC_W;
    localparam int ERR_DW = ERR_W + 1;

    t_state r_state, n_state;

    logic signed [GAIN_W-1:0]    r_kp, r_kd, r_ki;
    logic        [SENSOR_BITS-1:0] r_ref_zero, r_ref_ninety;
    logic        [DRIVE_W-1:0]   r_max_drive;

    logic signed [DEG_W-1:0]       r_deg;
    logic        [SENSOR_BITS-1:0] r_sample;
    logic        [ELAPSED_W-1:0]   r_elapsed;

    logic signed [ERR_W-1:0]   r_err, r_prev;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [PROD_W-1:0]  r_prod, r_plo;
    logic signed [WIDE_W-1:0]  r_wide;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_tneg, r_dneg;

    logic                    r_out_valid;
    logic [DRIVE_W-1:0]      r_drive_a, r_drive_b;
    logic signed [ERR_W-1:0] r_pos_err;

    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;

    logic                     div_start, div_busy;
    logic [DIV_NW-1:0]        div_num, div_quot;
    logic [DEN_W-1:0]         div_den;

    logic                     in_acc, out_load;
    logic signed [SENSOR_BITS:0] span;
    logic                     prod_neg;
    logic signed [PROD_W-1:0] prod_mag, p_biased, p_term;
    logic [TW-1:0]            tq_mag;
    logic signed [TW-1:0]     tgt_q, tgt, pos_diff;
    logic signed [ERR_W-1:0]  err_sat;
    logic signed [ERR_DW-1:0] err_diff;
    logic signed [INTEG_W:0]  integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [ACC_W-1:0]  d_mag, lim, drive;
    logic signed [INTEG_W-INTEG_LO_W-1:0] integ_hi;

    assign in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= '0;
            r_kd         <= '0;
            r_ki         <= '0;
            r_ref_zero   <= '0;
            r_ref_ninety <= '0;
            r_max_drive  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KP_GAIN:    r_kp         <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_KD_GAIN:    r_kd         <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_KI_GAIN:    r_ki         <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_REF_ZERO:   r_ref_zero   <= i_cfg_data[SENSOR_BITS-1:0];
                CFG_REF_NINETY: r_ref_ninety <= i_cfg_data[SENSOR_BITS-1:0];
                CFG_MAX_DRIVE:  r_max_drive  <= i_cfg_data[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operands
    assign span     = $signed({1'b0, r_ref_ninety}) - $signed({1'b0, r_ref_zero});
    assign err_diff = ERR_DW'(r_err) - ERR_DW'(r_prev);
    assign integ_hi = $signed(r_integ[INTEG_W-1:INTEG_LO_W]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SPAN: begin
                mul_a = MUL_AW'(span);
                mul_b = MUL_BW'(r_deg);
            end
            ST_EI: begin
                mul_a = $signed(MUL_AW'(r_elapsed));
                mul_b = MUL_BW'(r_err);
            end
            ST_INT: begin
                mul_a = MUL_AW'(r_kp);
                mul_b = MUL_BW'(r_err);
            end
            ST_PT: begin
                mul_a = MUL_AW'(r_kd);
                mul_b = MUL_BW'(err_diff);
            end
            ST_ILO: begin
                mul_a = MUL_AW'(r_ki);
                mul_b = $signed(MUL_BW'({1'b0, r_integ[INTEG_LO_W-1:0]}));
            end
            ST_IHI: begin
                mul_a = MUL_AW'(r_ki);
                mul_b = MUL_BW'(integ_hi);
            end
            default: ;
        endcase
    end

    // shared divider
    assign prod_neg  = r_prod[PROD_W-1];
    assign prod_mag  = prod_neg ? -r_prod : r_prod;
    assign div_num   = prod_mag[DIV_NW-1:0];
    assign div_start = (r_state == ST_TDIV) || (r_state == ST_ILO && r_elapsed != '0);
    assign div_den   = (r_state == ST_TDIV) ? DEN_W'(TGT_DIVISOR)
                                            : {r_elapsed, {FRAC_W{1'b0}}};

    pps_div #(
        .NUM_W    (DIV_NW),
        .DEN_BITS (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // target, error, integral, terms
    assign tq_mag   = {1'b0, div_quot[TW-2:0]};
    assign tgt_q    = r_tneg ? -$signed(tq_mag) : $signed(tq_mag);
    assign tgt      = tgt_q + $signed(TW'(r_ref_zero));
    assign pos_diff = tgt - $signed(TW'(r_sample));

    always_comb begin
        if (pos_diff > ERR_MAX) begin
            err_sat = ERR_W'(ERR_MAX);
        end else if (pos_diff < ERR_MIN) begin
            err_sat = ERR_W'(ERR_MIN);
        end else begin
            err_sat = ERR_W'(pos_diff);
        end
    end

    assign integ_sum = (INTEG_W + 1)'(r_integ) + (INTEG_W + 1)'(r_prod);

    always_comb begin
        if (integ_sum > INTEG_MAX) begin
            integ_sat = INTEG_MAX;
        end else if (integ_sum < INTEG_MIN) begin
            integ_sat = INTEG_MIN;
        end else begin
            integ_sat = INTEG_W'(integ_sum);
        end
    end

    assign p_biased = r_prod + $signed({{(PROD_W - FRAC_W){1'b0}}, {FRAC_W{prod_neg}}});
    assign p_term   = p_biased >>> FRAC_W;
    assign d_mag    = $signed(ACC_W'(div_quot));

    assign lim = $signed(ACC_W'(r_max_drive));
    always_comb begin
        if (r_acc > lim) begin
            drive = lim;
        end else if (r_acc < -lim) begin
            drive = -lim;
        end else begin
            drive = r_acc;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_SPAN;
            ST_SPAN:  n_state = ST_TDIV;
            ST_TDIV:  n_state = ST_TWAIT;
            ST_TWAIT: if (!div_busy) n_state = ST_ERR;
            ST_ERR:   n_state = ST_EI;
            ST_EI:    n_state = ST_INT;
            ST_INT:   n_state = ST_PT;
            ST_PT:    n_state = ST_ILO;
            ST_ILO:   n_state = ST_IHI;
            ST_IHI:   n_state = ST_ICOMB;
            ST_ICOMB: n_state = ST_IBIAS;
            ST_IBIAS: n_state = ST_IACC;
            ST_IACC:  n_state = ST_DWAIT;
            ST_DWAIT: if (!div_busy) n_state = ST_DACC;
            ST_DACC:  n_state = ST_DRIVE;
            ST_DRIVE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_INT) begin
                r_integ <= integ_sat;
            end
            if (r_state == ST_ILO) begin
                r_prev <= r_err;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_acc) begin
            r_deg     <= i_in.target_deg;
            r_sample  <= i_in.sensor_sample;
            r_elapsed <= i_in.elapsed_ms;
        end
        case (r_state)
            ST_TDIV:  r_tneg <= prod_neg;
            ST_ERR:   r_err  <= err_sat;
            ST_PT:    r_acc  <= ACC_W'(p_term);
            ST_ILO:   r_dneg <= prod_neg;
            ST_IHI:   r_plo  <= r_prod;
            ST_ICOMB: r_wide <= (WIDE_W'(r_prod) <<< INTEG_LO_W) + WIDE_W'(r_plo);
            ST_IBIAS: r_wide <= r_wide
                              + $signed({{(WIDE_W - FRAC_W){1'b0}},
                                         {FRAC_W{r_wide[WIDE_W-1]}}});
            ST_IACC:  r_acc  <= r_acc + ACC_W'(r_wide >>> FRAC_W);
            ST_DACC: begin
                if (r_elapsed != '0) begin
                    r_acc <= r_dneg ? r_acc - d_mag : r_acc + d_mag;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_drive_a <= (drive > 0) ? drive[DRIVE_W-1:0] : '0;
            r_drive_b <= (drive < 0) ? DRIVE_W'(-drive) : '0;
            r_pos_err <= r_err;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.drive_a        = r_drive_a;
    assign o_out.drive_b        = r_drive_b;
    assign o_out.position_error = r_pos_err;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_one_side_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_drive_a == '0 || r_drive_b == '0))
        else $error("both bridge sides driven");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == ST_SPAN)
        else $error("accepted item did not start the sequence");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRIVE && r_out_valid && !o_out.ready) |=> r_state == ST_DRIVE)
        else $error("result overwrote a pending item");
endmodule
`default_nettype wire
